// File: design/xgp_pkg.sv
// Shared types, constants and tables for the XOR grid pattern generator
package xgp_pkg;

  localparam int MIN_GRID_SIZE = 2;
  localparam int MAX_GRID_SIZE = 64;

  localparam int FRAC_W    = 16;
  localparam int COORD_W   = 32;
  localparam int TIME_W    = 32;
  localparam int INTENS_W  = 16;
  localparam int GRID_W    = 8;
  localparam int SPEED_W   = 16;
  localparam int CELL_W    = 8;
  localparam int PHASE_SH  = 6;
  localparam int PROD_LO_W = PHASE_SH + INTENS_W;
  localparam int DIV_W     = $clog2(MAX_GRID_SIZE);
  localparam int REM_W     = DIV_W + 1;

  // ramp numerator xr * 65535 stays below 2^NUM_W
  localparam int NUM_W       = CELL_W + FRAC_W;
  localparam int RECIP_SHIFT = NUM_W;
  localparam int KMUL_W      = RECIP_SHIFT + 1 + FRAC_W;
  localparam int QPROD_W     = CELL_W + KMUL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_SPEED = CFG_IDX_W'(1);

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(8);

  typedef logic [2**DIV_W-1:0][KMUL_W-1:0] kmul_tab_t;

  // floor(2^RECIP_SHIFT / d) by restoring long division
  function automatic logic [KMUL_W-1:0] recip_of(logic [DIV_W-1:0] d);
    logic [KMUL_W-1:0] q;
    logic [KMUL_W-1:0] r;
    q = '0;
    r = '0;
    for (int b = RECIP_SHIFT; b >= 0; b--) begin
      r = {r[KMUL_W-2:0], 1'(b == RECIP_SHIFT)};
      q = {q[KMUL_W-2:0], 1'b0};
      if (r >= KMUL_W'(d)) begin
        r    = r - KMUL_W'(d);
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Reciprocal of the divisor pre-multiplied by 65535, one entry per divisor
  function automatic kmul_tab_t build_kmul_tab();
    kmul_tab_t t;
    logic [KMUL_W-1:0] m;
    t = '0;
    for (int i = 1; i < 2**DIV_W; i++) begin
      m    = recip_of(DIV_W'(i));
      t[i] = (m << FRAC_W) - m;
    end
    return t;
  endfunction

  localparam kmul_tab_t KMUL_TAB = build_kmul_tab();

  typedef struct packed {
    logic [GRID_W-1:0]  grid;
    logic [DIV_W-1:0]   div;
    logic [KMUL_W-1:0]  kmul;
    logic [SPEED_W-1:0] speed;
  } cfg_t;

endpackage

// File: design/xgp_in_if.sv
// Input channel: pixel and frame transactions
interface xgp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic signed [xgp_pkg::COORD_W-1:0]    u_coord;
  logic signed [xgp_pkg::COORD_W-1:0]    v_coord;
  logic        [xgp_pkg::TIME_W-1:0]     elapsed_ms;

  modport source(output valid, func, u_coord, v_coord, elapsed_ms, input ready);
  modport sink(input valid, func, u_coord, v_coord, elapsed_ms, output ready);
endinterface

// File: design/xgp_out_if.sv
// Result channel: pixel intensity
interface xgp_out_if;
  logic                            valid;
  logic                            ready;
  logic [xgp_pkg::INTENS_W-1:0]    intensity;

  modport source(output valid, intensity, input ready);
  modport sink(input valid, intensity, output ready);
endinterface

// File: design/xgp_cfg_if.sv
// Configuration write channel
interface xgp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [xgp_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [xgp_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

// File: design/xgp_cfg_regs.sv
// Configuration registers with grid clamp and divisor reciprocal lookup
module xgp_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  xgp_cfg_if.sink       cfg_ch,
  output xgp_pkg::cfg_t cfg_o
);

  logic [xgp_pkg::GRID_W-1:0]  grid_r, grid_nxt;
  logic [xgp_pkg::DIV_W-1:0]   div_r, div_nxt;
  logic [xgp_pkg::KMUL_W-1:0]  kmul_r;
  logic [xgp_pkg::SPEED_W-1:0] speed_r;
  logic [xgp_pkg::GRID_W-1:0]  wr_grid;
  logic                        wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en   = cfg_ch.valid && cfg_ch.ready;
  assign wr_grid = cfg_ch.data[xgp_pkg::GRID_W-1:0];

  always_comb begin
    if (wr_grid < xgp_pkg::GRID_W'(xgp_pkg::MIN_GRID_SIZE)) begin
      grid_nxt = xgp_pkg::GRID_W'(xgp_pkg::MIN_GRID_SIZE);
    end else if (wr_grid > xgp_pkg::GRID_W'(xgp_pkg::MAX_GRID_SIZE)) begin
      grid_nxt = xgp_pkg::GRID_W'(xgp_pkg::MAX_GRID_SIZE);
    end else begin
      grid_nxt = wr_grid;
    end
    div_nxt = xgp_pkg::DIV_W'(grid_nxt - xgp_pkg::GRID_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r  <= xgp_pkg::GRID_RESET;
      div_r   <= xgp_pkg::DIV_W'(xgp_pkg::GRID_RESET - xgp_pkg::GRID_W'(1));
      kmul_r  <= xgp_pkg::KMUL_TAB[xgp_pkg::DIV_W'(xgp_pkg::GRID_RESET - xgp_pkg::GRID_W'(1))];
      speed_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_ch.reg_index)
        xgp_pkg::REG_GRID_SIZE: begin
          grid_r <= grid_nxt;
          div_r  <= div_nxt;
          kmul_r <= xgp_pkg::KMUL_TAB[div_nxt];
        end
        xgp_pkg::REG_ANIM_SPEED: begin
          speed_r <= cfg_ch.data[xgp_pkg::SPEED_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o.grid  = grid_r;
  assign cfg_o.div   = div_r;
  assign cfg_o.kmul  = kmul_r;
  assign cfg_o.speed = speed_r;

endmodule

// File: design/xgp_pipe.sv
// Four-stage datapath: cell index, reciprocal quotient, remainder, phase add
module xgp_pipe (
  input  logic          clk,
  input  logic          rst_n,
  input  xgp_pkg::cfg_t cfg,
  xgp_in_if.sink        in_ch,
  xgp_out_if.source     out_ch
);

  logic enable;

  // stage 1
  logic                             v1_r, f1_r;
  logic [xgp_pkg::CELL_W-1:0]       xr1_r;
  logic [xgp_pkg::INTENS_W-1:0]     ph1_r;
  // stage 2
  logic                             v2_r, f2_r;
  logic [xgp_pkg::NUM_W-1:0]        n2_r;
  logic [xgp_pkg::NUM_W-1:0]        qe2_r;
  logic [xgp_pkg::INTENS_W-1:0]     ph2_r;
  // stage 3
  logic                             v3_r, f3_r;
  logic [xgp_pkg::INTENS_W-1:0]     q3_r;
  logic [xgp_pkg::REM_W-1:0]        r3_r;
  logic [xgp_pkg::INTENS_W-1:0]     ph3_r;
  // output stage
  logic                             out_valid_r;
  logic [xgp_pkg::INTENS_W-1:0]     out_int_r;
  logic [xgp_pkg::INTENS_W-1:0]     phase_r;

  logic [xgp_pkg::FRAC_W+xgp_pkg::GRID_W-1:0] prod_u, prod_v;
  logic [xgp_pkg::PROD_LO_W-1:0]              prod_t;
  logic [xgp_pkg::QPROD_W-1:0]                prod_q;
  logic [xgp_pkg::NUM_W-1:0]                  qd, rem;
  logic                                       corr;
  logic [xgp_pkg::INTENS_W-1:0]               ramp;

  assign enable      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = enable;

  always_comb begin
    prod_u = (xgp_pkg::FRAC_W+xgp_pkg::GRID_W)'(in_ch.u_coord[xgp_pkg::FRAC_W-1:0])
           * (xgp_pkg::FRAC_W+xgp_pkg::GRID_W)'(cfg.grid);
    prod_v = (xgp_pkg::FRAC_W+xgp_pkg::GRID_W)'(in_ch.v_coord[xgp_pkg::FRAC_W-1:0])
           * (xgp_pkg::FRAC_W+xgp_pkg::GRID_W)'(cfg.grid);
    // only the low bits of elapsed * speed reach the phase field
    prod_t = in_ch.elapsed_ms[xgp_pkg::PROD_LO_W-1:0]
           * xgp_pkg::PROD_LO_W'(cfg.speed);
    prod_q = xgp_pkg::QPROD_W'(xr1_r) * xgp_pkg::QPROD_W'(cfg.kmul);
    qd     = qe2_r * xgp_pkg::NUM_W'(cfg.div);
    rem    = n2_r - qd;
    // estimate is at most one short
    corr   = r3_r >= xgp_pkg::REM_W'(cfg.div);
    ramp   = q3_r + xgp_pkg::INTENS_W'(corr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else if (enable) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r && !f3_r;
      if (v3_r && f3_r) begin
        phase_r <= ph3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      f1_r  <= in_ch.func;
      xr1_r <= prod_u[xgp_pkg::FRAC_W +: xgp_pkg::CELL_W]
             ^ prod_v[xgp_pkg::FRAC_W +: xgp_pkg::CELL_W];
      ph1_r <= prod_t[xgp_pkg::PHASE_SH +: xgp_pkg::INTENS_W];

      f2_r  <= f1_r;
      n2_r  <= {xr1_r, xgp_pkg::FRAC_W'(0)} - xgp_pkg::NUM_W'(xr1_r);
      qe2_r <= prod_q[xgp_pkg::RECIP_SHIFT +: xgp_pkg::NUM_W];
      ph2_r <= ph1_r;

      f3_r  <= f2_r;
      q3_r  <= qe2_r[xgp_pkg::INTENS_W-1:0];
      r3_r  <= rem[xgp_pkg::REM_W-1:0];
      ph3_r <= ph2_r;

      out_int_r <= ramp + phase_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.intensity = out_int_r;

endmodule

// File: design/xor_grid_pattern_generator.sv
// XOR grid pattern generator top level.
// A pixel transaction passes through the stage 1, stage 2, stage 3 and output registers
// before it is presented on out_ch.
// Throughput: one transaction per cycle while out_ch is not stalled, set by the four-stage datapath; frame
// transactions pass through the same stages and update the phase without a result.
// Reset: synchronous on rst_n low; clears stage valids and phase, grid_size to 8,
// anim_speed to 0.
module xor_grid_pattern_generator (
  input  logic       clk,
  input  logic       rst_n,
  xgp_in_if.sink     in_ch,
  xgp_out_if.source  out_ch,
  xgp_cfg_if.sink    cfg_ch
);

  xgp_pkg::cfg_t cfg;

  xgp_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  xgp_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.grid >= xgp_pkg::GRID_W'(xgp_pkg::MIN_GRID_SIZE)
    && cfg.grid <= xgp_pkg::GRID_W'(xgp_pkg::MAX_GRID_SIZE))
    else $error("grid size outside clamp range");

  a_div_match: assert property (@(posedge clk) disable iff (!rst_n)
    xgp_pkg::GRID_W'(cfg.div) == cfg.grid - xgp_pkg::GRID_W'(1))
    else $error("divisor out of step with grid size");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the XOR grid pattern generator
`timescale 1ns / 1ps

module tb_top;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;

  // register indexes past the implemented pair; writes there must be ignored
  localparam logic [xgp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = xgp_pkg::CFG_IDX_W'(2);
  localparam logic [xgp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = xgp_pkg::CFG_IDX_W'(3);

  localparam int PIPE_LATENCY  = 4;
  localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY + 2;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;

  logic clk;
  logic rst_n;

  xgp_in_if  in_ch();
  xgp_out_if out_ch();
  xgp_cfg_if cfg_ch();

  xor_grid_pattern_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the block's registers and phase
  logic [xgp_pkg::GRID_W-1:0]   mdl_grid;
  logic [xgp_pkg::SPEED_W-1:0]  mdl_speed;
  logic [xgp_pkg::INTENS_W-1:0] mdl_phase;

  logic [xgp_pkg::INTENS_W-1:0] intensity_q[$];
  logic [xgp_pkg::INTENS_W-1:0] oldest_intensity;

  int errors;
  int n_pixels;
  int n_frames;
  int n_writes;
  int n_checked;
  int cycle_count;
  int stall_cnt;
  int burst_left;
  bit steady_sender;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [xgp_pkg::GRID_W-1:0] clamp_grid(logic [xgp_pkg::GRID_W-1:0] d);
    if (d < xgp_pkg::GRID_W'(xgp_pkg::MIN_GRID_SIZE)) return xgp_pkg::GRID_W'(xgp_pkg::MIN_GRID_SIZE);
    if (d > xgp_pkg::GRID_W'(xgp_pkg::MAX_GRID_SIZE)) return xgp_pkg::GRID_W'(xgp_pkg::MAX_GRID_SIZE);
    return d;
  endfunction

  function automatic logic [xgp_pkg::INTENS_W-1:0] xor_intensity(
      logic signed [xgp_pkg::COORD_W-1:0] u,
      logic signed [xgp_pkg::COORD_W-1:0] v,
      logic [xgp_pkg::GRID_W-1:0] grid,
      logic [xgp_pkg::INTENS_W-1:0] ph);
    logic [23:0] pu;
    logic [23:0] pv;
    logic [7:0]  xr;
    logic [31:0] divisor;
    logic [31:0] ramp;
    // low 16 bits are the fraction of a turn; cell index sits above the fraction
    pu = u[15:0] * grid;
    pv = v[15:0] * grid;
    xr = pu[23:16] ^ pv[23:16];
    divisor = (grid > 1) ? 32'(grid) - 32'd1 : 32'd1;
    ramp = (32'(xr) * 32'd65535) / divisor;
    return ramp[15:0] + ph;
  endfunction

  function automatic logic [xgp_pkg::INTENS_W-1:0] frame_phase(
      logic [xgp_pkg::TIME_W-1:0] t,
      logic [xgp_pkg::SPEED_W-1:0] spd);
    logic [31:0] prod;
    prod = t * spd;
    return prod[21:6];
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  // scoreboard: results are checked before this edge's transactions are predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (intensity_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result intensity=%h", out_ch.intensity));
        end else begin
          oldest_intensity = intensity_q.pop_front();
          n_checked++;
          if (out_ch.intensity !== oldest_intensity)
            report_mismatch($sformatf("intensity got %h want %h",
                                      out_ch.intensity, oldest_intensity));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_FRAME) begin
          mdl_phase = frame_phase(in_ch.elapsed_ms, mdl_speed);
          n_frames++;
        end else begin
          intensity_q.push_back(xor_intensity(in_ch.u_coord, in_ch.v_coord,
                                              mdl_grid, mdl_phase));
          n_pixels++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        n_writes++;
        case (cfg_ch.reg_index)
          xgp_pkg::REG_GRID_SIZE:  mdl_grid = clamp_grid(cfg_ch.data[xgp_pkg::GRID_W-1:0]);
          xgp_pkg::REG_ANIM_SPEED: mdl_speed = cfg_ch.data[xgp_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // receiver: steps through four ready modes selected by stall_cnt[9:8]
  always @(posedge clk) begin
    stall_cnt++;
    case (stall_cnt[9:8])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (stall_cnt[2:0] != 3'd5) && (stall_cnt[2:0] != 3'd6);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // called at a rising edge; returns once the transaction has gone through
  task automatic send_item(input logic func, input logic signed [xgp_pkg::COORD_W-1:0] u,
                           input logic signed [xgp_pkg::COORD_W-1:0] v,
                           input logic [xgp_pkg::TIME_W-1:0] t);
    in_ch.func       <= func;
    in_ch.u_coord    <= u;
    in_ch.v_coord    <= v;
    in_ch.elapsed_ms <= t;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (!steady_sender) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic send_pixel(input logic signed [xgp_pkg::COORD_W-1:0] u,
                            input logic signed [xgp_pkg::COORD_W-1:0] v);
    send_item(FUNC_PIXEL, u, v, xgp_pkg::TIME_W'($urandom));
  endtask

  task automatic send_frame(input logic [xgp_pkg::TIME_W-1:0] t);
    send_item(FUNC_FRAME, xgp_pkg::COORD_W'($urandom), xgp_pkg::COORD_W'($urandom), t);
  endtask

  // frames give no result, so wait out the pipeline once the queue is empty
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (intensity_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [xgp_pkg::CFG_IDX_W-1:0] idx,
                              input logic [xgp_pkg::CFG_DATA_W-1:0] d);
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= d;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    send_pixel(-32'sd1, 32'sh0000_0000);
    send_pixel(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_pixel(32'sh0000_FFFF, 32'shFFFF_0000);
    send_pixel(32'sh0001_2000, -32'sh0000_2000);
    // zero speed keeps the phase at zero whatever the time
    send_frame(32'hFFFF_FFFF);
    send_pixel(32'sh0000_E000, 32'sh0000_2000);
  endtask

  task automatic test_frame_phase();
    settle_idle();
    set_register(xgp_pkg::REG_ANIM_SPEED, 16'hFFFF);
    send_frame(32'hFFFF_FFFF);
    send_pixel(32'sh0000_4000, 32'sh0000_0000);
    send_frame(32'h0000_0000);
    send_pixel(32'sh0000_FFFF, 32'sh0000_0000);
    send_frame(32'h0000_1234);
    send_pixel(-32'sd1, -32'sd1);
  endtask

  task automatic test_grid_clamp();
    logic [xgp_pkg::CFG_DATA_W-1:0] grid_writes[7];
    grid_writes = '{16'h0000, 16'h0001, 16'h0002, 16'h0040, 16'h0041, 16'h00FF, 16'hFF05};
    foreach (grid_writes[i]) begin
      settle_idle();
      set_register(xgp_pkg::REG_GRID_SIZE, grid_writes[i]);
      send_pixel(32'sh0000_FFFF, 32'sh0000_8000);
    end
    // grid of three: cells 1 and 2 XOR to 3, past the top of the ramp
    settle_idle();
    set_register(xgp_pkg::REG_GRID_SIZE, 16'h0003);
    send_pixel(32'sh0000_6000, 32'sh0000_C000);
    settle_idle();
    set_register(REG_SPARE_A, 16'hFFFF);
    set_register(REG_SPARE_B, 16'h0001);
    send_pixel(32'sh0000_C000, 32'sh0000_6000);
  endtask

  function automatic logic signed [xgp_pkg::COORD_W-1:0] random_coord();
    case ($urandom_range(0, 3))
      0, 1:    return xgp_pkg::COORD_W'($urandom);
      2:       return xgp_pkg::COORD_W'($urandom_range(0, 65535));
      default: return -xgp_pkg::COORD_W'($urandom_range(0, 262143));
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [xgp_pkg::CFG_DATA_W-1:0] grid_data;
    logic [xgp_pkg::CFG_DATA_W-1:0] speed_data;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          grid_data  = 16'h0040;
          speed_data = 16'hFFFF;
        end
        1: begin
          grid_data  = 16'h0002;
          speed_data = 16'h0000;
        end
        default: begin
          grid_data  = ($urandom_range(0, 3) == 0) ? xgp_pkg::CFG_DATA_W'($urandom)
                       : {8'($urandom), 8'($urandom_range(0, 70))};
          speed_data = xgp_pkg::CFG_DATA_W'($urandom);
        end
      endcase
      settle_idle();
      set_register(xgp_pkg::REG_GRID_SIZE, grid_data);
      set_register(xgp_pkg::REG_ANIM_SPEED, speed_data);
      if (p == 4) set_register(REG_SPARE_B, xgp_pkg::CFG_DATA_W'($urandom));
      steady_sender = (p % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) settle_idle();
        if ($urandom_range(0, 99) < 12) send_frame(xgp_pkg::TIME_W'($urandom));
        else send_pixel(random_coord(), random_coord());
      end
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_PIXEL;
    in_ch.u_coord    = '0;
    in_ch.v_coord    = '0;
    in_ch.elapsed_ms = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = xgp_pkg::REG_GRID_SIZE;
    cfg_ch.data      = '0;
    out_ch.ready     = 1'b0;
    mdl_grid         = clamp_grid(xgp_pkg::GRID_RESET);
    mdl_speed        = '0;
    mdl_phase        = '0;
    errors           = 0;
    n_pixels         = 0;
    n_frames         = 0;
    n_writes         = 0;
    n_checked        = 0;
    cycle_count      = 0;
    stall_cnt        = 0;
    burst_left       = $urandom_range(1, 24);
    steady_sender    = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_frame_phase();
    test_grid_clamp();
    test_random_traffic();
    settle_idle();

    $display("Ran %0d pixel and %0d frame transactions with %0d register writes",
             n_pixels, n_frames, n_writes);
    $display("Compared %0d intensities over %0d random settings, %0d errors",
             n_checked, RANDOM_PHASES, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
